// ===== sv/rfp_pkg.sv =====
// rangefinder frame parser package: constants, state encoding and result type
// used by the interfaces, the parse core, the output stage and the top level
package rfp_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 11;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned DIST_W          = 16;
  localparam int unsigned KEPT_BYTES      = 6;

  localparam logic [BYTE_W-1:0] HDR0     = 8'h55;
  localparam logic [BYTE_W-1:0] HDR1     = 8'h0c;
  localparam logic [BYTE_W-1:0] HDR2     = 8'h0b;
  localparam logic [BYTE_W-1:0] SUM_SEED = 8'h6c;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  localparam logic DIR_FORWARD = 1'b0;

  typedef enum logic [3:0] {
    ST_HUNT0   = 4'b0001,
    ST_HUNT1   = 4'b0010,
    ST_HUNT2   = 4'b0100,
    ST_PAYLOAD = 4'b1000
  } rfp_state_t;

  typedef struct packed {
    logic              frame_status;
    logic [DIST_W-1:0] obstacle_cm;
    logic [DIST_W-1:0] ground_cm;
  } rfp_result_t;

endpackage

// ===== sv/rfp_ifs.sv =====
// valid/ready channel interfaces for the received byte stream and the results
// depends on rfp_pkg for field widths
interface rfp_in_if;
  import rfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfp_out_if;
  import rfp_pkg::*;
  logic              valid;
  logic              ready;
  logic              frame_status;
  logic [DIST_W-1:0] obstacle_cm;
  logic [DIST_W-1:0] ground_cm;
  modport source (output valid, output frame_status, output obstacle_cm,
                  output ground_cm, input ready);
  modport sink (input valid, input frame_status, input obstacle_cm,
                input ground_cm, output ready);
endinterface

// ===== sv/rfp_parse_core.sv =====
// header hunt, payload capture and additive checksum for one byte per step
// depends on rfp_pkg
module rfp_parse_core #(
  parameter int unsigned FRAME_BYTES = rfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [rfp_pkg::BYTE_W-1:0] byte_in,
  input  logic                       dir_mode,
  output logic                       res_valid,
  output rfp_pkg::rfp_result_t       res
);
  import rfp_pkg::*;

  localparam int unsigned PAYLOAD_LEN = FRAME_BYTES - 3;
  localparam int unsigned CNT_W       = $clog2(PAYLOAD_LEN);

  rfp_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] store_r [KEPT_BYTES];
  logic              is_last;
  logic              csum_ok;

  assign is_last = (cnt_r == CNT_W'(PAYLOAD_LEN - 1));
  assign csum_ok = (sum_r == byte_in);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    if (step) begin
      case (state_r)
        ST_HUNT0: begin
          state_nxt = (byte_in == HDR0) ? ST_HUNT1 : ST_HUNT0;
        end
        ST_HUNT1: begin
          state_nxt = (byte_in == HDR1) ? ST_HUNT2 : ST_HUNT0;
        end
        ST_HUNT2: begin
          if (byte_in == HDR2) begin
            state_nxt = ST_PAYLOAD;
            cnt_nxt   = '0;
            sum_nxt   = SUM_SEED;
          end else begin
            state_nxt = ST_HUNT0;
          end
        end
        ST_PAYLOAD: begin
          if (is_last) begin
            res_valid = 1'b1;
            state_nxt = ST_HUNT0;
            cnt_nxt   = '0;
            sum_nxt   = SUM_SEED;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
            sum_nxt = sum_r + byte_in;
          end
        end
        default: begin
          state_nxt = ST_HUNT0;
        end
      endcase
    end
  end

  always_comb begin
    res.frame_status = csum_ok ? STATUS_OK : STATUS_CSUM_ERR;
    res.obstacle_cm  = '0;
    res.ground_cm    = '0;
    if (csum_ok) begin
      res.obstacle_cm = (dir_mode == DIR_FORWARD) ? {store_r[2], store_r[3]}
                                                  : {store_r[4], store_r[5]};
      res.ground_cm   = {store_r[1], store_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT0;
      cnt_r   <= '0;
      sum_r   <= SUM_SEED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // only the first six payload bytes are ever read
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEPT_BYTES; i++) begin
      if (step && state_r == ST_PAYLOAD && cnt_r == CNT_W'(i)) begin
        store_r[i] <= byte_in;
      end
    end
  end

  a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (state_r == ST_HUNT0) && (cnt_r == '0) && (sum_r == SUM_SEED))
    else $error("frame end did not return to hunting");

  a_count_idle_outside_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_PAYLOAD) |-> (cnt_r == '0))
    else $error("byte count nonzero outside payload");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_status == STATUS_CSUM_ERR)
      |-> (res.obstacle_cm == '0) && (res.ground_cm == '0))
    else $error("checksum error result carries distances");

  a_result_only_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> $past(state_r) == ST_PAYLOAD || state_r == ST_PAYLOAD)
    else $error("result outside payload");

endmodule

// ===== sv/rfp_out_stage.sv =====
// result register driving the output channel
// depends on rfp_pkg and rfp_out_if
module rfp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rfp_pkg::rfp_result_t res,
  output logic                 can_load,
  rfp_out_if.source            out_ch
);
  import rfp_pkg::*;

  logic        valid_r, valid_nxt;
  rfp_result_t data_r;

  assign can_load  = !valid_r || out_ch.ready;
  assign valid_nxt = push ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.frame_status = data_r.frame_status;
  assign out_ch.obstacle_cm  = data_r.obstacle_cm;
  assign out_ch.ground_cm    = data_r.ground_cm;

endmodule

// ===== sv/rangefinder_frame_parser_top.sv =====
// Rangefinder frame parser. Takes one serial byte per item, hunts for the
// header 55 0c 0b, collects FRAME_BYTES-3 payload bytes and emits one result
// per frame: status (0 ok, 1 checksum error), obstacle and ground distance.
// Throughput is one byte per cycle; a byte waits in the input register only
// while the result register holds an untaken result. A result is registered
// once the core takes the last byte. cfg_wdata selects the obstacle bytes
// (0 forward, 1 other direction) and is meant to be written while idle.
module rangefinder_frame_parser_top #(
  parameter int unsigned FRAME_BYTES = rfp_pkg::FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rfp_in_if.sink    in_ch,
  rfp_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import rfp_pkg::*;

  logic              inq_valid_r, inq_valid_nxt;
  logic [BYTE_W-1:0] inq_byte_r;
  logic              dir_mode_r;
  logic              can_load;
  logic              advance;
  logic              in_take;
  logic              res_valid;
  rfp_result_t       res;

  assign advance     = inq_valid_r && can_load;
  assign in_ch.ready = !inq_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign inq_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : inq_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      dir_mode_r  <= DIR_FORWARD;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      if (cfg_we) begin
        dir_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inq_byte_r <= in_ch.rx_byte;
    end
  end

  rfp_parse_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .byte_in   (inq_byte_r),
    .dir_mode  (dir_mode_r),
    .res_valid (res_valid),
    .res       (res)
  );

  rfp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
